>>> src/urhr_pkg.sv
// Shared types and codes of the undo/redo history ring.
// Holds the command codes and the request and response beat structs.
// Depends on nothing; undo_redo_history_ring and its testbench import it.
package urhr_pkg;

    // Fixed field widths of one beat
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned TYPE_W = 3;
    localparam int unsigned TAGP_W = 16;
    localparam int unsigned COLP_W = 16;
    localparam int unsigned REF_W  = 32;
    localparam int unsigned LEN_W  = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNDO  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REDO  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INVAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TYPE_W-1:0] in_op_type;
        logic [TAGP_W-1:0] line_tag;
        logic [COLP_W-1:0] in_column;
        logic [REF_W-1:0]  in_payload_ref;
        logic [LEN_W-1:0]  in_payload_len;
    } req_item_t;

    typedef struct packed {
        logic              done_res;
        logic [TYPE_W-1:0] out_op_type;
        logic [TAGP_W-1:0] out_line_tag;
        logic [COLP_W-1:0] out_column;
        logic [REF_W-1:0]  out_payload_ref;
        logic [LEN_W-1:0]  out_payload_len;
        logic              undo_ready;
        logic              redo_ready;
    } rsp_item_t;

endpackage

>>> src/urhr_ram.sv
// Single-port-write, single-port-read record memory with registered read data.
// Generic storage for the history ring; no package dependency.
// Used by undo_redo_history_ring.
module urhr_ram #(
    parameter int unsigned WIDTH = 84,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/undo_redo_history_ring.sv
// Undo/redo history ring: records live in urhr_ram, a sequencer walks them.
// Every command ends with two status reads and a finish step; undo/redo first read their record,
// and invalidate first walks the stored records unless the tag is zero or the ring is empty.
// One command at a time: busy high until its result beat is shown.
// The invalidate walk (one read port, a read per slot, then a write if it matches) sets the longest case.
// Receiver cannot stall. Reset clears the pointers at once.
module undo_redo_history_ring #(
    parameter int unsigned RING_DEPTH  = 64,
    parameter int unsigned TAG_BITS    = 16,
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  urhr_pkg::req_item_t req,
    output logic              busy,
    output logic              strobe,
    output urhr_pkg::rsp_item_t rsp
);

    import urhr_pkg::*;

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    // Record word layout: {valid, type, tag, column, ref, len}
    localparam int unsigned LEN_LO  = 0;
    localparam int unsigned REF_LO  = LEN_LO + LEN_W;
    localparam int unsigned COL_LO  = REF_LO + REF_W;
    localparam int unsigned TAG_LO  = COL_LO + COLUMN_BITS;
    localparam int unsigned TYPE_LO = TAG_LO + TAG_BITS;
    localparam int unsigned VLD_BIT = TYPE_LO + TYPE_W;
    localparam int unsigned WORD_W  = VLD_BIT + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNDO_RD,
        ST_UNDO_CHK,
        ST_REDO_RD,
        ST_REDO_CHK,
        ST_INV_RD,
        ST_INV_CHK,
        ST_STAT_U,
        ST_STAT_R,
        ST_FIN
    } state_t;

    state_t                 state_reg, state_next;
    req_item_t              item_reg, item_next;
    logic [AW-1:0]          oldest_reg, oldest_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          redo_reg, redo_next;
    logic [CW-1:0]          walk_reg, walk_next;
    logic                   done_reg, done_next;
    logic [WORD_W-1:0]      rec_reg, rec_next;
    logic                   uok_reg, uok_next;
    logic                   strobe_reg, strobe_next;
    rsp_item_t              rsp_reg, rsp_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [WORD_W-1:0]      mem_rdata;

    logic [31:0]            req_tag_wide;
    logic [31:0]            item_tag_wide;
    logic [31:0]            req_col_wide;
    logic [TAG_BITS-1:0]    req_tag;
    logic [TAG_BITS-1:0]    item_tag;
    logic [COLUMN_BITS-1:0] req_col;
    logic [CW-1:0]          undo_off;
    logic [CW-1:0]          redo_off;
    logic                   undo_exists;
    logic                   redo_exists;
    logic [31:0]            rec_tag_wide;
    logic [31:0]            rec_col_wide;

    // Map a window offset to a ring slot
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW + 1)'(base) + (AW + 1)'(off);
        if (sum >= (AW + 1)'(RING_DEPTH))
        begin
            sum = sum - (AW + 1)'(RING_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    urhr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fit tag and column to their stored widths
    assign req_tag_wide  = 32'(req.line_tag);
    assign item_tag_wide = 32'(item_reg.line_tag);
    assign req_col_wide  = 32'(req.in_column);
    assign req_tag       = req_tag_wide[TAG_BITS-1:0];
    assign item_tag      = item_tag_wide[TAG_BITS-1:0];
    assign req_col       = req_col_wide[COLUMN_BITS-1:0];

    // Offsets of the next undo and redo records in the window
    assign undo_exists = redo_reg < count_reg;
    assign redo_exists = redo_reg != '0;
    assign undo_off    = undo_exists ? (count_reg - redo_reg - CW'(1)) : '0;
    assign redo_off    = redo_exists ? (count_reg - redo_reg) : '0;

    assign rec_tag_wide = 32'(rec_reg[TAG_LO +: TAG_BITS]);
    assign rec_col_wide = 32'(rec_reg[COL_LO +: COLUMN_BITS]);

    // Sequence one command through the record memory
    always_comb
    begin
        logic [CW-1:0] kept;
        logic [AW-1:0] slot;
        kept = '0;
        slot = '0;

        state_next  = state_reg;
        item_next   = item_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        redo_next   = redo_reg;
        walk_next   = walk_reg;
        done_next   = done_reg;
        rec_next    = rec_reg;
        uok_next    = uok_reg;
        strobe_next = 1'b0;
        rsp_next    = rsp_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = req;
                    done_next  = 1'b0;
                    rec_next   = '0;
                    state_next = ST_STAT_U;
                    case (req.cmd)
                        CMD_PUSH:
                        begin
                            // Drop redo history, then append or overwrite oldest
                            kept = count_reg - redo_reg;
                            if (kept < CW'(RING_DEPTH))
                            begin
                                slot       = slot_at(oldest_reg, kept);
                                count_next = kept + CW'(1);
                            end
                            else
                            begin
                                slot = oldest_reg;
                                if (oldest_reg == AW'(RING_DEPTH - 1))
                                begin
                                    oldest_next = '0;
                                end
                                else
                                begin
                                    oldest_next = oldest_reg + AW'(1);
                                end
                            end
                            redo_next = '0;
                            mem_we    = 1'b1;
                            mem_waddr = slot;
                            mem_wdata = {1'b1, req.in_op_type, req_tag, req_col,
                                         req.in_payload_ref, req.in_payload_len};
                        end
                        CMD_UNDO:
                        begin
                            state_next = ST_UNDO_RD;
                        end
                        CMD_REDO:
                        begin
                            state_next = ST_REDO_RD;
                        end
                        CMD_INVAL:
                        begin
                            if (req_tag != '0 && count_reg != '0)
                            begin
                                walk_next  = '0;
                                state_next = ST_INV_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            oldest_next = '0;
                            count_next  = '0;
                            redo_next   = '0;
                        end
                        default:
                        begin
                            state_next = ST_STAT_U;
                        end
                    endcase
                end
            end
            ST_UNDO_RD:
            begin
                mem_raddr  = slot_at(oldest_reg, undo_off);
                state_next = undo_exists ? ST_UNDO_CHK : ST_STAT_U;
            end
            ST_UNDO_CHK:
            begin
                if (mem_rdata[VLD_BIT])
                begin
                    redo_next = redo_reg + CW'(1);
                    done_next = 1'b1;
                    rec_next  = mem_rdata;
                end
                state_next = ST_STAT_U;
            end
            ST_REDO_RD:
            begin
                mem_raddr  = slot_at(oldest_reg, redo_off);
                state_next = redo_exists ? ST_REDO_CHK : ST_STAT_U;
            end
            ST_REDO_CHK:
            begin
                if (mem_rdata[VLD_BIT])
                begin
                    redo_next = redo_reg - CW'(1);
                    done_next = 1'b1;
                    rec_next  = mem_rdata;
                end
                state_next = ST_STAT_U;
            end
            ST_INV_RD:
            begin
                mem_raddr  = slot_at(oldest_reg, walk_reg);
                state_next = ST_INV_CHK;
            end
            ST_INV_CHK:
            begin
                // Clear valid, tag and length of a matching live slot
                if (mem_rdata[VLD_BIT] && mem_rdata[TAG_LO +: TAG_BITS] == item_tag)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_at(oldest_reg, walk_reg);
                    mem_wdata = mem_rdata;
                    mem_wdata[VLD_BIT]              = 1'b0;
                    mem_wdata[TAG_LO +: TAG_BITS]   = '0;
                    mem_wdata[LEN_LO +: LEN_W]      = '0;
                end
                walk_next = walk_reg + CW'(1);
                if (walk_reg + CW'(1) == count_reg)
                begin
                    state_next = ST_STAT_U;
                end
                else
                begin
                    state_next = ST_INV_RD;
                end
            end
            ST_STAT_U:
            begin
                mem_raddr  = slot_at(oldest_reg, undo_off);
                state_next = ST_STAT_R;
            end
            ST_STAT_R:
            begin
                uok_next   = undo_exists && mem_rdata[VLD_BIT];
                mem_raddr  = slot_at(oldest_reg, redo_off);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Build the result beat
                rsp_next.done_res        = done_reg;
                rsp_next.out_op_type     = rec_reg[TYPE_LO +: TYPE_W];
                rsp_next.out_line_tag    = rec_tag_wide[TAGP_W-1:0];
                rsp_next.out_column      = rec_col_wide[COLP_W-1:0];
                rsp_next.out_payload_ref = rec_reg[REF_LO +: REF_W];
                rsp_next.out_payload_len = rec_reg[LEN_LO +: LEN_W];
                rsp_next.undo_ready      = uok_reg;
                rsp_next.redo_ready      = redo_exists && mem_rdata[VLD_BIT];
                strobe_next              = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            item_reg   <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            redo_reg   <= '0;
            walk_reg   <= '0;
            done_reg   <= 1'b0;
            rec_reg    <= '0;
            uok_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            redo_reg   <= redo_next;
            walk_reg   <= walk_next;
            done_reg   <= done_next;
            rec_reg    <= rec_next;
            uok_reg    <= uok_next;
            strobe_reg <= strobe_next;
            rsp_reg    <= rsp_next;
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    // Window bookkeeping stays consistent
    a_redo_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        redo_reg <= count_reg)
        else $error("redo depth exceeds stored count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RING_DEPTH))
        else $error("stored count exceeds ring depth");

    // A result beat only follows the final sequencer step
    a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_FIN))
        else $error("result beat without finish step");

    // A successful undo leaves that record redoable, and vice versa
    a_undo_then_redo: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.done_res && item_reg.cmd == CMD_UNDO) |-> rsp_reg.redo_ready)
        else $error("undone record not redoable");

    a_redo_then_undo: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.done_res && item_reg.cmd == CMD_REDO) |-> rsp_reg.undo_ready)
        else $error("redone record not undoable");

    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && item_reg.cmd == CMD_PUSH) |-> (rsp_reg.undo_ready && !rsp_reg.redo_ready))
        else $error("push left wrong ready flags");

endmodule

>>> sim/undo_redo_history_ring_tb.sv
// Self-checking testbench for undo_redo_history_ring: directed and random command beats.
// A built-in predictor of the history ring checks every result beat.
// Depends on urhr_pkg and the undo_redo_history_ring RTL.
module undo_redo_history_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urhr_pkg::*;

    localparam int RING         = 64;
    localparam int ITEMS_TARGET = 1200;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 2 * RING + 16;

    // Spare command codes that the block must treat as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct {
        req_item_t req;
        bit        wait_drain;
    } pending_beat_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    req_item_t req;
    logic      busy;
    logic      strobe;
    rsp_item_t rsp;

    pending_beat_t edit_queue[$];
    rsp_item_t     expected_rsp[$];
    int            items_queued;
    int            beats_sent;
    int            results_seen;
    int            mismatch_count;
    int            cycle_count;

    // Shadow copy of the history ring
    logic [TYPE_W-1:0] hist_type  [RING];
    logic [TAGP_W-1:0] hist_tag   [RING];
    logic [COLP_W-1:0] hist_column[RING];
    logic [REF_W-1:0]  hist_ref   [RING];
    logic [LEN_W-1:0]  hist_len   [RING];
    bit                hist_valid [RING];
    int                oldest;
    int                held;
    int                undone;

    undo_redo_history_ring #(
        .RING_DEPTH (RING),
        .TAG_BITS   (16),
        .COLUMN_BITS(16)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .strobe(strobe),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int hist_pos(int offset);
        return (oldest + offset) % RING;
    endfunction

    function automatic bit undo_open();
        if (undone >= held)
            return 1'b0;
        return hist_valid[hist_pos(held - undone - 1)];
    endfunction

    function automatic bit redo_open();
        if (undone == 0)
            return 1'b0;
        return hist_valid[hist_pos(held - undone)];
    endfunction

    // Apply one command beat to the shadow ring and return its result beat
    function automatic rsp_item_t predict_history(req_item_t r);
        rsp_item_t o;
        int        slot;
        bit        hit;
        o    = '0;
        slot = 0;
        hit  = 1'b0;
        case (r.cmd)
            CMD_PUSH:
            begin
                // drop the redo history, then append or overwrite the oldest
                for (int i = 0; i < undone; i++)
                    hist_valid[hist_pos(held - 1 - i)] = 1'b0;
                held   = held - undone;
                undone = 0;
                if (held < RING)
                begin
                    slot = hist_pos(held);
                    held++;
                end
                else
                begin
                    slot   = oldest;
                    oldest = (oldest + 1) % RING;
                end
                hist_type[slot]   = r.in_op_type;
                hist_tag[slot]    = r.line_tag;
                hist_column[slot] = r.in_column;
                hist_ref[slot]    = r.in_payload_ref;
                hist_len[slot]    = r.in_payload_len;
                hist_valid[slot]  = 1'b1;
            end
            CMD_UNDO:
            begin
                if (undo_open())
                begin
                    slot = hist_pos(held - undone - 1);
                    undone++;
                    hit = 1'b1;
                end
            end
            CMD_REDO:
            begin
                if (redo_open())
                begin
                    slot = hist_pos(held - undone);
                    undone--;
                    hit = 1'b1;
                end
            end
            CMD_INVAL:
            begin
                if (r.line_tag != '0)
                    for (int i = 0; i < RING; i++)
                        if (hist_valid[i] && hist_tag[i] == r.line_tag)
                        begin
                            hist_valid[i] = 1'b0;
                            hist_tag[i]   = '0;
                            hist_len[i]   = '0;
                        end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < RING; i++)
                    hist_valid[i] = 1'b0;
                oldest = 0;
                held   = 0;
                undone = 0;
            end
            default:
            begin
            end
        endcase
        o.done_res = hit;
        if (hit)
        begin
            o.out_op_type     = hist_type[slot];
            o.out_line_tag    = hist_tag[slot];
            o.out_column      = hist_column[slot];
            o.out_payload_ref = hist_ref[slot];
            o.out_payload_len = hist_len[slot];
        end
        o.undo_ready = undo_open();
        o.redo_ready = redo_open();
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h, wanted %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_edit(logic [CMD_W-1:0] code, logic [TYPE_W-1:0] kind,
                              logic [TAGP_W-1:0] tag, logic [COLP_W-1:0] col,
                              logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen);
        pending_beat_t b;
        b.req            = '0;
        b.req.cmd        = code;
        b.req.in_op_type = kind;
        b.req.line_tag   = tag;
        b.req.in_column  = col;
        b.req.in_payload_ref = pref;
        b.req.in_payload_len = plen;
        b.wait_drain     = 1'b0;
        edit_queue.push_back(b);
        items_queued++;
    endtask

    task automatic queue_drain();
        pending_beat_t b;
        b.req        = '0;
        b.wait_drain = 1'b1;
        edit_queue.push_back(b);
    endtask

    // Mostly a small pool so that invalidates hit, sometimes zero or any value
    function automatic logic [TAGP_W-1:0] pick_tag();
        int w;
        w = $urandom_range(0, 99);
        if (w < 70)
            return TAGP_W'($urandom_range(1, 8));
        if (w < 80)
            return '0;
        return TAGP_W'($urandom_range(0, 65535));
    endfunction

    // Non-push commands carry random noise in the unused fields
    task automatic queue_cmd(logic [CMD_W-1:0] code, logic [TAGP_W-1:0] tag);
        queue_edit(code, TYPE_W'($urandom_range(0, 5)), tag,
                   COLP_W'($urandom_range(0, 65535)), $urandom,
                   LEN_W'($urandom_range(0, 65535)));
    endtask

    task automatic queue_random_push();
        queue_edit(CMD_PUSH, TYPE_W'($urandom_range(0, 5)), pick_tag(),
                   COLP_W'($urandom_range(0, 65535)), $urandom,
                   LEN_W'($urandom_range(0, 65535)));
    endtask

    task automatic queue_mixed_cmd();
        int w;
        w = $urandom_range(0, 99);
        if (w < 40)
            queue_random_push();
        else if (w < 62)
            queue_cmd(CMD_UNDO, pick_tag());
        else if (w < 80)
            queue_cmd(CMD_REDO, pick_tag());
        else if (w < 92)
            queue_cmd(CMD_INVAL, pick_tag());
        else if (w < 95)
            queue_cmd(CMD_CLEAR, pick_tag());
        else
            queue_cmd(CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 2)), pick_tag());
    endtask

    // Present command beats; pop the next one only once the current beat is taken
    always @(posedge clk)
    begin : drive_commands
        logic          next_start;
        int            idle_pct;
        pending_beat_t nxt;
        if (rst_n)
        begin
            next_start = start;
            if (start && !busy)
            begin
                expected_rsp.push_back(predict_history(req));
                beats_sent++;
                next_start = 1'b0;
            end
            if (!next_start && edit_queue.size() != 0)
            begin
                if (edit_queue[0].wait_drain)
                begin
                    // hold off until every result beat is back
                    if (expected_rsp.size() == 0)
                        void'(edit_queue.pop_front());
                end
                else
                begin
                    idle_pct = (beats_sent < 450) ? 25 : (beats_sent < 850) ? 51 : 0;
                    if ($urandom_range(0, 99) >= idle_pct)
                    begin
                        nxt = edit_queue.pop_front();
                        req <= nxt.req;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        rsp_item_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("unexpected beat", 32'(rsp), '0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(rsp.done_res), 32'(want.done_res));
                if (rsp.out_op_type !== want.out_op_type)
                    report_mismatch("out_op_type", 32'(rsp.out_op_type),
                                    32'(want.out_op_type));
                if (rsp.out_line_tag !== want.out_line_tag)
                    report_mismatch("out_line_tag", 32'(rsp.out_line_tag),
                                    32'(want.out_line_tag));
                if (rsp.out_column !== want.out_column)
                    report_mismatch("out_column", 32'(rsp.out_column), 32'(want.out_column));
                if (rsp.out_payload_ref !== want.out_payload_ref)
                    report_mismatch("out_payload_ref", rsp.out_payload_ref,
                                    want.out_payload_ref);
                if (rsp.out_payload_len !== want.out_payload_len)
                    report_mismatch("out_payload_len", 32'(rsp.out_payload_len),
                                    32'(want.out_payload_len));
                if (rsp.undo_ready !== want.undo_ready)
                    report_mismatch("undo_ready", 32'(rsp.undo_ready), 32'(want.undo_ready));
                if (rsp.redo_ready !== want.redo_ready)
                    report_mismatch("redo_ready", 32'(rsp.redo_ready), 32'(want.redo_ready));
            end
            results_seen++;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("undo_redo_history_ring regression: fail");
            $finish;
        end
    end

    initial
    begin : run_regression
        int pick;
        int run_len;
        bit drain_mid;
        bit drain_late;

        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        items_queued   = 0;
        beats_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        oldest         = 0;
        held           = 0;
        undone         = 0;
        for (int i = 0; i < RING; i++)
        begin
            hist_type[i]   = '0;
            hist_tag[i]    = '0;
            hist_column[i] = '0;
            hist_ref[i]    = '0;
            hist_len[i]    = '0;
            hist_valid[i]  = 1'b0;
        end

        // Directed: empty ring, field extremes, blocked undo, redo drop, spare codes
        queue_cmd(CMD_UNDO, '0);
        queue_cmd(CMD_REDO, '0);
        queue_cmd(CMD_INVAL, '0);
        queue_edit(CMD_PUSH, '0, '0, '0, '0, '0);
        queue_edit(CMD_PUSH, TYPE_W'(5), '1, '1, '1, '1);
        queue_edit(CMD_PUSH, TYPE_W'(1), TAGP_W'(5), COLP_W'(12), 32'h1234_5678, LEN_W'(3));
        queue_edit(CMD_PUSH, TYPE_W'(2), TAGP_W'(7), COLP_W'(40), 32'hDEAD_BEEF, LEN_W'(9));
        queue_edit(CMD_PUSH, TYPE_W'(3), TAGP_W'(5), COLP_W'(77), 32'h0F0F_0F0F, LEN_W'(1));
        queue_cmd(CMD_INVAL, '0);
        queue_cmd(CMD_INVAL, TAGP_W'(7));
        queue_cmd(CMD_UNDO, pick_tag());
        queue_cmd(CMD_UNDO, pick_tag());
        queue_cmd(CMD_REDO, pick_tag());
        queue_cmd(CMD_UNDO, pick_tag());
        queue_edit(CMD_PUSH, TYPE_W'(4), TAGP_W'(9), COLP_W'(2), 32'h8000_0001, LEN_W'(256));
        queue_cmd(CMD_REDO, pick_tag());
        queue_cmd(CMD_SPARE_FIRST, pick_tag());
        queue_cmd(CMD_SPARE_FIRST + CMD_W'(1), pick_tag());
        queue_cmd(CMD_SPARE_LAST, pick_tag());
        queue_cmd(CMD_INVAL, TAGP_W'(5));
        queue_cmd(CMD_UNDO, pick_tag());
        queue_cmd(CMD_CLEAR, pick_tag());
        queue_cmd(CMD_UNDO, pick_tag());
        queue_drain();

        // Random: runs of pushes, undos and redos that wrap the ring, plus noise
        drain_mid  = 1'b0;
        drain_late = 1'b0;
        while (items_queued < ITEMS_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                run_len = $urandom_range(1, 80);
                repeat (run_len) queue_random_push();
            end
            else if (pick < 45)
            begin
                run_len = $urandom_range(1, 70);
                repeat (run_len) queue_cmd(CMD_UNDO, pick_tag());
            end
            else if (pick < 57)
            begin
                run_len = $urandom_range(1, 70);
                repeat (run_len) queue_cmd(CMD_REDO, pick_tag());
            end
            else if (pick < 62)
                queue_cmd(CMD_INVAL, pick_tag());
            else if (pick < 64)
                queue_cmd(CMD_CLEAR, pick_tag());
            else if (pick < 66)
                queue_cmd(CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 2)), pick_tag());
            else
            begin
                run_len = $urandom_range(5, 20);
                repeat (run_len) queue_mixed_cmd();
            end
            // let the ring go quiet around the idle-pattern changes
            if (!drain_mid && items_queued >= 450)
            begin
                queue_drain();
                drain_mid = 1'b1;
            end
            if (!drain_late && items_queued >= 850)
            begin
                queue_drain();
                drain_late = 1'b1;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to be taken and answered, then watch for strays
        @(posedge clk);
        while (edit_queue.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("undo_redo_history_ring regression: pass");
        else
            $display("undo_redo_history_ring regression: fail");
        $finish;
    end

endmodule

>>> files.f
src/urhr_pkg.sv
src/urhr_ram.sv
src/undo_redo_history_ring.sv
sim/undo_redo_history_ring_tb.sv
